FILE: rtl/core/min_3x3_window_sum_assert.svh
// Assertion macros for the minimum 3x3 window sum block.
// Expects i_clk and i_rst_n in the scope of every use.
`ifndef MIN_3X3_WINDOW_SUM_ASSERT_SVH
`define MIN_3X3_WINDOW_SUM_ASSERT_SVH

// Same-cycle implication, checked outside reset
`define MWS_ASSERT_NOW(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, checked outside reset
`define MWS_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

FILE: rtl/core/mws_pkg.sv
// Shared constants and types for the minimum 3x3 window sum block.
// No dependencies; imported by the top level.
`timescale 1ns / 1ps

package mws_pkg;

    localparam int MAX_WIDTH   = 1024;
    localparam int ADDR_BITS   = $clog2(MAX_WIDTH);
    localparam int WIDTH_BITS  = 11;
    localparam int SAMPLE_BITS = 32;
    localparam int COL_BITS    = SAMPLE_BITS + 2;
    localparam int SUM_BITS    = 36;
    localparam int LINE_BITS   = 2 * SAMPLE_BITS;

    // Window edge: rows and columns needed before a window is complete
    localparam logic [1:0]           ROWS_FULL     = 2'd2;
    localparam logic [ADDR_BITS-1:0] FIRST_WIN_COL = ADDR_BITS'(2);
    localparam logic [WIDTH_BITS-1:0] WIDTH_RESET  = WIDTH_BITS'(MAX_WIDTH);
    localparam logic [WIDTH_BITS-1:0] WIDTH_MAX    = WIDTH_BITS'(MAX_WIDTH);

    typedef logic signed [SAMPLE_BITS-1:0] t_sample;
    typedef logic signed [COL_BITS-1:0]    t_col_sum;
    typedef logic signed [SUM_BITS-1:0]    t_win_sum;
    typedef logic [ADDR_BITS-1:0]          t_col_idx;

endpackage

FILE: rtl/core/min_3x3_window_sum.sv
// Minimum 3x3 window sum over a raster stream of signed samples.
// The result is registered: the last-of-frame sample passes stage 1, then loads the output register.
// Throughput: one sample per cycle; input stalls only while a result waits.
// Reset (synchronous, active low): clears frame state and output valid, row width to 1024.
// Line-buffer RAM contents are not cleared by reset.
// Depends on mws_pkg, mws_ram and min_3x3_window_sum_assert.svh.
`timescale 1ns / 1ps

module min_3x3_window_sum
    import mws_pkg::*;
(
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    // Configuration write channel
    input  logic                  i_cfg_valid,
    output logic                  o_cfg_ready,
    input  logic [WIDTH_BITS-1:0] i_cfg_data,
    // Sample input channel
    input  logic                  i_valid,
    output logic                  o_ready,
    input  logic [SAMPLE_BITS-1:0] i_sample_value,
    input  logic                  i_last_of_frame,
    // Result channel
    output logic                  o_valid,
    input  logic                  i_ready,
    output logic [SUM_BITS-1:0]   o_min_sum,
    output logic                  o_window_found
);

`include "min_3x3_window_sum_assert.svh"

    // Configuration and input-side frame state
    logic [WIDTH_BITS-1:0] r_row_width;
    t_col_idx              r_col_idx;
    logic [1:0]            r_rows_seen;

    // Stage 1 registers (aligned with RAM read data)
    logic     r_s1_valid;
    t_sample  r_s1_sample;
    logic     r_s1_last;
    logic     r_s1_win;
    logic     r_s1_row_end;
    t_col_idx r_s1_col;

    // Read-during-write bypass
    logic                 r_byp_valid;
    logic [LINE_BITS-1:0] r_byp_data;

    // Datapath state
    t_col_sum r_prev0;
    t_col_sum r_prev1;
    t_win_sum r_min;
    logic     r_any;

    // Output register
    logic                r_o_valid;
    logic [SUM_BITS-1:0] r_o_min;
    logic                r_o_found;

    logic [WIDTH_BITS-1:0] eff_width;
    t_col_idx              cur_col;
    logic                  row_end;
    logic                  in_fire;
    logic                  s1_fire;
    logic [LINE_BITS-1:0]  ram_rdata;
    logic [LINE_BITS-1:0]  line_data;
    logic [LINE_BITS-1:0]  ram_wdata;
    t_sample               above_one;
    t_sample               above_two;
    t_col_sum              col_sum;
    t_win_sum              win_sum;
    t_win_sum              n_min;
    logic                  n_any;

    // Configuration: always ready; it must be written only while idle, a rule the block itself does not enforce
    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_row_width <= WIDTH_RESET;
        end else if (i_cfg_valid) begin
            r_row_width <= i_cfg_data;
        end
    end

    // Clamp the row width and wrap the column index
    always_comb begin
        if (r_row_width == '0) begin
            eff_width = WIDTH_BITS'(1);
        end else if (r_row_width > WIDTH_MAX) begin
            eff_width = WIDTH_MAX;
        end else begin
            eff_width = r_row_width;
        end
        cur_col = ({1'b0, r_col_idx} >= eff_width) ? '0 : r_col_idx;
        row_end = ({1'b0, cur_col} + WIDTH_BITS'(1)) >= eff_width;
    end

    // Handshakes
    assign s1_fire = r_s1_valid && (!r_s1_last || !r_o_valid || i_ready);
    assign o_ready = !r_s1_valid || s1_fire;
    assign in_fire = i_valid && o_ready;

    // Advance column and row counters on each input transaction
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_col_idx   <= '0;
            r_rows_seen <= '0;
        end else if (in_fire) begin
            if (i_last_of_frame) begin
                r_col_idx   <= '0;
                r_rows_seen <= '0;
            end else if (row_end) begin
                r_col_idx <= '0;
                if (r_rows_seen < ROWS_FULL) begin
                    r_rows_seen <= r_rows_seen + 2'd1;
                end
            end else begin
                r_col_idx <= cur_col + t_col_idx'(1);
            end
        end
    end

    // Stage 1 capture
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid <= 1'b0;
        end else if (in_fire) begin
            r_s1_valid <= 1'b1;
        end else if (s1_fire) begin
            r_s1_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_fire) begin
            r_s1_sample  <= i_sample_value;
            r_s1_last    <= i_last_of_frame;
            r_s1_win     <= (r_rows_seen == ROWS_FULL) && (cur_col >= FIRST_WIN_COL);
            r_s1_row_end <= row_end;
            r_s1_col     <= cur_col;
        end
    end

    // Line buffers: one entry holds {two rows above, one row above}
    mws_ram #(
        .WIDTH (LINE_BITS),
        .DEPTH (MAX_WIDTH)
    ) u_line_ram (
        .i_clk   (i_clk),
        .i_we    (s1_fire),
        .i_waddr (r_s1_col),
        .i_wdata (ram_wdata),
        .i_re    (in_fire),
        .i_raddr (cur_col),
        .o_rdata (ram_rdata)
    );

    // Catch a read of the address written in the same cycle (one-sample rows)
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_byp_valid <= 1'b0;
        end else if (in_fire) begin
            r_byp_valid <= s1_fire && (r_s1_col == cur_col);
        end else if (s1_fire) begin
            r_byp_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_fire) begin
            r_byp_data <= ram_wdata;
        end
    end

    // Column sum and window sum
    always_comb begin
        line_data = r_byp_valid ? r_byp_data : ram_rdata;
        above_one = line_data[SAMPLE_BITS-1:0];
        above_two = line_data[LINE_BITS-1:SAMPLE_BITS];
        ram_wdata = {above_one, r_s1_sample};
        col_sum   = t_col_sum'(r_s1_sample) + t_col_sum'(above_one)
                  + t_col_sum'(above_two);
        win_sum   = t_win_sum'(col_sum) + t_win_sum'(r_prev0) + t_win_sum'(r_prev1);
        n_min     = r_min;
        n_any     = r_any;
        if (r_s1_win) begin
            if (!r_any || (win_sum < r_min)) begin
                n_min = win_sum;
            end
            n_any = 1'b1;
        end
    end

    // Update column history and running minimum; clear history at row end, and all of it after the frame ends
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_prev0 <= '0;
            r_prev1 <= '0;
            r_min   <= '0;
            r_any   <= 1'b0;
        end else if (s1_fire) begin
            if (r_s1_last) begin
                r_prev0 <= '0;
                r_prev1 <= '0;
                r_min   <= '0;
                r_any   <= 1'b0;
            end else begin
                r_min <= n_min;
                r_any <= n_any;
                if (r_s1_row_end) begin
                    r_prev0 <= '0;
                    r_prev1 <= '0;
                end else begin
                    r_prev0 <= col_sum;
                    r_prev1 <= r_prev0;
                end
            end
        end
    end

    // Output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_o_valid <= 1'b0;
        end else if (s1_fire && r_s1_last) begin
            r_o_valid <= 1'b1;
        end else if (i_ready) begin
            r_o_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (s1_fire && r_s1_last) begin
            r_o_min   <= n_any ? n_min : '0;
            r_o_found <= n_any;
        end
    end

    assign o_valid        = r_o_valid;
    assign o_min_sum      = r_o_min;
    assign o_window_found = r_o_found;

    // Checks
    `MWS_ASSERT_NEXT(a_result_after_last, s1_fire && r_s1_last, r_o_valid,
        "result register not loaded after last-of-frame sample")
    `MWS_ASSERT_NOW(a_no_window_zero, r_o_valid && !r_o_found, r_o_min == '0,
        "min_sum nonzero without a window")
    `MWS_ASSERT_NOW(a_rows_saturate, 1'b1, r_rows_seen <= ROWS_FULL,
        "row counter past saturation")
    `MWS_ASSERT_NOW(a_bypass_needs_item, r_byp_valid, r_s1_valid,
        "bypass set with empty stage")
    `MWS_ASSERT_NEXT(a_stall_holds_stage, r_s1_valid && !s1_fire, r_s1_valid,
        "stalled stage lost its sample")

endmodule

FILE: rtl/core/mws_ram.sv
// Generic simple dual-port RAM: one write port, one read port, registered read.
// No dependencies.
`timescale 1ns / 1ps

module mws_ram #(
    parameter int WIDTH = 64,
    parameter int DEPTH = 1024,
    localparam int ABITS = $clog2(DEPTH)
) (
    input  logic             i_clk,
    input  logic             i_we,
    input  logic [ABITS-1:0] i_waddr,
    input  logic [WIDTH-1:0] i_wdata,
    input  logic             i_re,
    input  logic [ABITS-1:0] i_raddr,
    output logic [WIDTH-1:0] o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    // Write port
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
    end

    // Read port, data held until the next read
    always_ff @(posedge i_clk) begin
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

FILE: tb/sv/min_3x3_window_sum_test.sv
// Self-checking testbench for min_3x3_window_sum: raster frames in, one minimum per frame out.
// Depends on mws_pkg for port widths and on the min_3x3_window_sum RTL.
`timescale 1ns / 1ps

module min_3x3_window_sum_test;
    import mws_pkg::*;

    typedef struct packed {
        logic [SUM_BITS-1:0] min_sum;
        logic                window_found;
    } t_frame_min;

    // DUT ports, every input driven to a known value from time zero
    logic                   i_clk           = 1'b0;
    logic                   i_rst_n         = 1'b0;
    logic                   i_cfg_valid     = 1'b0;
    logic                   o_cfg_ready;
    logic [WIDTH_BITS-1:0]  i_cfg_data      = '0;
    logic                   i_valid         = 1'b0;
    logic                   o_ready;
    logic [SAMPLE_BITS-1:0] i_sample_value  = '0;
    logic                   i_last_of_frame = 1'b0;
    logic                   o_valid;
    logic                   i_ready         = 1'b0;
    logic [SUM_BITS-1:0]    o_min_sum;
    logic                   o_window_found;

    int send_idle_pct = 0;
    int recv_idle_pct = 0;
    int error_count   = 0;

    // Expected frame minima, oldest first
    t_frame_min expected_mins[$];

    // Shadow of the block's frame state
    logic [WIDTH_BITS-1:0] shadow_width = WIDTH_RESET;
    t_sample               shadow_row_one [MAX_WIDTH];
    t_sample               shadow_row_two [MAX_WIDTH];
    longint                col_sum_back1  = 0;
    longint                col_sum_back2  = 0;
    longint                min_so_far     = 0;
    int unsigned           cur_col        = 0;
    int unsigned           full_rows      = 0;
    bit                    window_seen    = 1'b0;

    min_3x3_window_sum dut (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_cfg_valid     (i_cfg_valid),
        .o_cfg_ready     (o_cfg_ready),
        .i_cfg_data      (i_cfg_data),
        .i_valid         (i_valid),
        .o_ready         (o_ready),
        .i_sample_value  (i_sample_value),
        .i_last_of_frame (i_last_of_frame),
        .o_valid         (o_valid),
        .i_ready         (i_ready),
        .o_min_sum       (o_min_sum),
        .o_window_found  (o_window_found)
    );

    // 2 ns clock
    always begin
        #1 i_clk = 1'b1;
        #1 i_clk = 1'b0;
    end

    // Row width as the block applies it: zero acts as one, oversize clamps
    function automatic int unsigned active_width(input logic [WIDTH_BITS-1:0] w);
        if (w == 0)
            return 1;
        if (w > WIDTH_MAX)
            return MAX_WIDTH;
        return int'(w);
    endfunction

    // Advance the shadow state by one sample; queue the frame minimum on last
    function automatic void predict_window_min(input t_sample s, input logic last);
        int unsigned eff;
        int unsigned c;
        longint      col;
        longint      win;
        t_frame_min  res;
        eff = active_width(shadow_width);
        if (cur_col >= eff)
            cur_col = 0;
        c = cur_col;
        col = longint'(s) + longint'(shadow_row_one[c]) + longint'(shadow_row_two[c]);
        if (full_rows >= 2 && c >= 2) begin
            win = col + col_sum_back1 + col_sum_back2;
            if (!window_seen || win < min_so_far)
                min_so_far = win;
            window_seen = 1'b1;
        end
        col_sum_back2     = col_sum_back1;
        col_sum_back1     = col;
        shadow_row_two[c] = shadow_row_one[c];
        shadow_row_one[c] = s;
        if (c + 1 >= eff) begin
            cur_col       = 0;
            col_sum_back1 = 0;
            col_sum_back2 = 0;
            if (full_rows < 2)
                full_rows++;
        end else begin
            cur_col = c + 1;
        end
        if (last) begin
            res.min_sum      = window_seen ? SUM_BITS'(min_so_far) : '0;
            res.window_found = window_seen;
            expected_mins.insert(expected_mins.size(), res);
            col_sum_back1 = 0;
            col_sum_back2 = 0;
            cur_col       = 0;
            full_rows     = 0;
            min_so_far    = 0;
            window_seen   = 1'b0;
        end
    endfunction

    // Check each result transaction against the oldest expectation; stall at random
    always @(posedge i_clk) begin : check_results
        t_frame_min exp_min;
        if (i_rst_n && o_valid && i_ready) begin
            if (expected_mins.size() == 0) begin
                $display("%0t ns: unexpected result, actual min_sum %0d window_found %0b",
                         $time, $signed(o_min_sum), o_window_found);
                error_count++;
            end else begin
                exp_min = expected_mins.pop_front();
                if (o_min_sum !== exp_min.min_sum) begin
                    $display("%0t ns: min_sum mismatch, expected %0d actual %0d",
                             $time, $signed(exp_min.min_sum), $signed(o_min_sum));
                    error_count++;
                end
                if (o_window_found !== exp_min.window_found) begin
                    $display("%0t ns: window_found mismatch, expected %0b actual %0b",
                             $time, exp_min.window_found, o_window_found);
                    error_count++;
                end
            end
        end
        i_ready <= ($urandom_range(0, 99) >= recv_idle_pct);
    end

    // Send one sample transaction, idling first at random
    task automatic send_sample(input t_sample s, input logic last);
        if ($urandom_range(0, 99) < send_idle_pct) begin
            i_valid <= 1'b0;
            do @(posedge i_clk); while ($urandom_range(0, 99) < send_idle_pct);
        end
        i_valid         <= 1'b1;
        i_sample_value  <= s;
        i_last_of_frame <= last;
        do @(posedge i_clk); while (!o_ready);
        predict_window_min(s, last);
    endtask

    // Drop valid, wait for every expected result, then let the pipeline settle
    task automatic drain_results();
        i_valid <= 1'b0;
        do @(posedge i_clk); while (expected_mins.size() != 0);
        repeat (4) @(posedge i_clk);
    endtask

    // Write the row width; call only while the block is idle
    task automatic write_row_width(input logic [WIDTH_BITS-1:0] w);
        i_cfg_valid <= 1'b1;
        i_cfg_data  <= w;
        do @(posedge i_clk); while (!o_cfg_ready);
        i_cfg_valid  <= 1'b0;
        shadow_width = w;
    endtask

    function automatic t_sample pick_sample();
        case ($urandom_range(0, 7))
            0:       return 32'sh7FFF_FFFF;
            1:       return 32'sh8000_0000;
            2:       return t_sample'(int'($urandom_range(0, 31)) - 16);
            default: return t_sample'($urandom);
        endcase
    endfunction

    function automatic logic [WIDTH_BITS-1:0] pick_row_width();
        case ($urandom_range(0, 9))
            0:       return '0;
            1:       return WIDTH_BITS'(1);
            2:       return WIDTH_BITS'(2);
            3:       return WIDTH_BITS'($urandom_range(MAX_WIDTH + 1, 2 ** WIDTH_BITS - 1));
            4:       return WIDTH_BITS'($urandom_range(9, 24));
            default: return WIDTH_BITS'($urandom_range(3, 8));
        endcase
    endfunction

    // A frame shorter than one row at the reset row width: no window may form
    task automatic test_reset_width();
        int n;
        n = 200;
        for (int k = 0; k < n; k++)
            send_sample(pick_sample(), k == n - 1);
        drain_results();
    endtask

    // Extreme sums, tiny grids, clamped widths and a frame ending mid-row
    task automatic test_corner_frames();
        // Largest possible window sum
        write_row_width(WIDTH_BITS'(3));
        for (int k = 0; k < 9; k++)
            send_sample(32'sh7FFF_FFFF, k == 8);
        drain_results();
        // Smallest window sum, frame closed on the first sample of the fourth row
        for (int k = 0; k < 9; k++)
            send_sample(32'sh8000_0000, 1'b0);
        send_sample('0, 1'b1);
        drain_results();
        // Zero width behaves as one column: no window
        write_row_width('0);
        send_sample(32'sh8000_0000, 1'b0);
        send_sample(32'sh7FFF_FFFF, 1'b1);
        drain_results();
        write_row_width(WIDTH_BITS'(1));
        send_sample(32'sh0000_0005, 1'b0);
        send_sample(32'shFFFF_FFFB, 1'b1);
        drain_results();
        // Widest legal width and an oversized width, single-sample frames
        write_row_width(WIDTH_MAX);
        send_sample(32'sh1234_5678, 1'b1);
        drain_results();
        write_row_width('1);
        send_sample(32'sh8765_4321, 1'b1);
        drain_results();
        // Three rows of two columns: too narrow for a window
        write_row_width(WIDTH_BITS'(2));
        for (int k = 0; k < 6; k++)
            send_sample(pick_sample(), k == 5);
        drain_results();
    endtask

    // Random frames: mostly complete grids, some cut short
    task automatic test_random_frames(input int item_goal);
        int          sent;
        int          n;
        int unsigned eff;
        sent = 0;
        while (sent < item_goal) begin
            if ($urandom_range(0, 1))
                write_row_width(pick_row_width());
            eff = active_width(shadow_width);
            if (eff > 64)
                n = $urandom_range(1, 12);
            else if ($urandom_range(0, 4) == 0)
                n = $urandom_range(1, 2 * eff + 2);
            else begin
                n = eff * $urandom_range(3, (eff > 8) ? 4 : 5);
                if ($urandom_range(0, 3) == 0)
                    n += $urandom_range(0, eff - 1);
            end
            for (int k = 0; k < n; k++)
                send_sample(pick_sample(), k == n - 1);
            sent += n;
            drain_results();
        end
    endtask

    initial begin
        foreach (shadow_row_one[k]) begin
            shadow_row_one[k] = '0;
            shadow_row_two[k] = '0;
        end
        repeat (4) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        send_idle_pct = 28;
        recv_idle_pct = 84;
        test_reset_width();
        test_corner_frames();
        test_random_frames(150);

        send_idle_pct = 84;
        recv_idle_pct = 28;
        test_random_frames(150);

        send_idle_pct = 0;
        recv_idle_pct = 0;
        test_random_frames(150);

        if (error_count == 0)
            $display("PASS min_3x3_window_sum");
        else
            $display("FAIL min_3x3_window_sum");
        $finish;
    end

    // Hard stop well beyond the slowest correct run
    initial begin
        #1000000;
        $display("FAIL min_3x3_window_sum");
        $finish;
    end

endmodule

FILE: files.f
+incdir+rtl/core
rtl/core/mws_pkg.sv
rtl/core/mws_ram.sv
rtl/core/min_3x3_window_sum.sv
tb/sv/min_3x3_window_sum_test.sv
